>>> sv/fftd_pkg.sv
`timescale 1ns / 1ps

package fftd_pkg;

    localparam int FFTD_TOUCH_SLOTS = 16;
    localparam int FFTD_TAP_FINGERS = 4;

    localparam int SLOT_W  = 4;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;
    localparam int PATH_W  = 24;
    localparam logic [PATH_W-1:0] PATH_MAX = '1;

    localparam int RAD_W  = 34;
    localparam int ROOT_W = 17;
    localparam int REM_W  = 19;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_W      = 16;

    localparam logic [CFG_W-1:0] MIN_GATHER   = 16'd10;
    localparam logic [CFG_W-1:0] SLOP_RESET   = 16'd160;
    localparam logic [CFG_W-1:0] GATHER_RESET = 16'd150;
    localparam logic [CFG_W-1:0] HOLD_RESET   = 16'd300;

    localparam logic [1:0] REG_SLOP   = 2'd0;
    localparam logic [1:0] REG_GATHER = 2'd1;
    localparam logic [1:0] REG_HOLD   = 2'd2;

    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] touch_slot;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [TIME_W-1:0] time_ms;
    } touch_req_t;

    typedef struct packed {
        logic               decided;
        logic               fired;
        logic [COUNT_W-1:0] fingers_left;
        logic [COUNT_W-1:0] peak_fingers;
        logic               was_spoiled;
    } touch_res_t;

    typedef struct packed {
        logic [POS_W-1:0]  last_x;
        logic [POS_W-1:0]  last_y;
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] down_time;
    } slot_rec_t;

    typedef struct packed {
        logic [CFG_W-1:0] slop;
        logic [CFG_W-1:0] gather_lim;
        logic [CFG_W-1:0] hold_lim;
    } cfg_t;

endpackage

>>> sv/fftd_ram.sv
`timescale 1ns / 1ps

module fftd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fftd_sqrt.sv
`timescale 1ns / 1ps

module fftd_sqrt
    import fftd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {{(REM_W - ROOT_W){1'b0}}, root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (rem_shift >= trial) begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/fftd_cfg.sv
`timescale 1ns / 1ps

module fftd_cfg
    import fftd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [CFG_W-1:0] slop_reg, slop_next;
    logic [CFG_W-1:0] gather_reg, gather_next;
    logic [CFG_W-1:0] hold_reg, hold_next;
    logic [1:0]       reg_index;
    logic             wr_en;
    logic [CFG_W-1:0] gather_eff;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        slop_next   = slop_reg;
        gather_next = gather_reg;
        hold_next   = hold_reg;
        if (wr_en) begin
            unique case (reg_index)
                REG_SLOP:   slop_next   = pwdata[CFG_W-1:0];
                REG_GATHER: gather_next = pwdata[CFG_W-1:0];
                REG_HOLD:   hold_next   = pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_SLOP:   prdata = CFG_DATA_W'(slop_reg);
            REG_GATHER: prdata = CFG_DATA_W'(gather_reg);
            REG_HOLD:   prdata = CFG_DATA_W'(hold_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slop_reg   <= SLOP_RESET;
            gather_reg <= GATHER_RESET;
            hold_reg   <= HOLD_RESET;
        end else begin
            slop_reg   <= slop_next;
            gather_reg <= gather_next;
            hold_reg   <= hold_next;
        end
    end

    assign gather_eff     = (gather_reg < MIN_GATHER) ? MIN_GATHER : gather_reg;
    assign cfg.slop       = slop_reg;
    assign cfg.gather_lim = gather_eff;
    assign cfg.hold_lim   = (hold_reg > gather_eff) ? hold_reg : gather_eff;

endmodule

>>> sv/four_finger_tap_detector.sv
`timescale 1ns / 1ps

// Channel   Ports                         Request carries
// input     s_valid, s_ready, s_data      one touch event (touch_req_t)
// result    m_valid, m_ready, m_data      one verdict per finger up (touch_res_t)
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A down event passes the fetch and execute states; an up event also passes the output state, plus any wait on m_ready.
// A move event makes two passes of the shared 16 by 16 multiplier
// and seventeen steps of the bit-serial square root unit.
// Reset is synchronous and active low; it clears the slot occupancy and gesture state.
// A result waits in the output register while the next request is taken.

module four_finger_tap_detector
    import fftd_pkg::*;
#(
    parameter int TOUCH_SLOTS = FFTD_TOUCH_SLOTS,
    parameter int TAP_FINGERS = FFTD_TAP_FINGERS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  touch_req_t            s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output touch_res_t            m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;
    localparam int REC_W = $bits(slot_rec_t);
    localparam logic [COUNT_W-1:0] TAP_COUNT = COUNT_W'(TAP_FINGERS);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FETCH = 9'b000000010,
        ST_EXEC  = 9'b000000100,
        ST_SQX   = 9'b000001000,
        ST_SQY   = 9'b000010000,
        ST_GO    = 9'b000100000,
        ST_ROOT  = 9'b001000000,
        ST_ACC   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    touch_req_t             req_reg, req_next;
    slot_rec_t              rec_reg, rec_next;
    logic [TOUCH_SLOTS-1:0] occ_reg, occ_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     peak_reg, peak_next;
    logic                   spoiled_reg, spoiled_next;
    logic [TIME_W-1:0]      start_reg, start_next;
    logic [POS_W-1:0]       dx_reg, dx_next;
    logic [POS_W-1:0]       dy_reg, dy_next;
    logic [RAD_W-1:0]       sumsq_reg, sumsq_next;
    touch_res_t             res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    touch_res_t             m_data_reg, m_data_next;

    cfg_t              cfg;
    slot_rec_t         rec_rd;
    logic [REC_W-1:0]  ram_rdata;
    slot_rec_t         rec_wr;
    logic              ram_we;
    logic [AW-1:0]     slot_addr;
    logic              slot_valid;
    logic              slot_occ;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    logic               new_gest;
    logic [TIME_W-1:0]  start_eff;
    logic [COUNT_W-1:0] count_dn;
    logic [COUNT_W-1:0] peak_base;
    logic [COUNT_W-1:0] peak_dn;
    logic [TIME_W-1:0]  gather_el;
    logic               spoil_dn;
    logic [TIME_W-1:0]  held;
    logic               spoil_up;
    logic [COUNT_W-1:0] count_up;
    logic [POS_W-1:0]   mul_op;
    logic [2*POS_W-1:0] prod;
    logic [PATH_W:0]    path_sum;
    logic [PATH_W-1:0]  path_new;

    fftd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fftd_ram #(
        .WIDTH (REC_W),
        .DEPTH (TOUCH_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (rec_wr),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    fftd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sumsq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign rec_rd     = ram_rdata;
    assign slot_addr  = AW'(req_reg.touch_slot);
    assign slot_valid = int'(req_reg.touch_slot) < TOUCH_SLOTS;
    assign slot_occ   = slot_valid && occ_reg[slot_addr];
    assign sqrt_start = (state_reg == ST_GO);

    assign new_gest  = (count_reg == '0);
    assign start_eff = new_gest ? req_reg.time_ms : start_reg;
    assign count_dn  = slot_occ ? count_reg : count_reg + 1'b1;
    assign peak_base = new_gest ? '0 : peak_reg;
    assign peak_dn   = (count_dn > peak_base) ? count_dn : peak_base;
    assign gather_el = req_reg.time_ms - start_eff;
    assign spoil_dn  = (!new_gest && spoiled_reg) || (count_dn > TAP_COUNT)
                       || (gather_el > TIME_W'(cfg.gather_lim));

    assign held     = slot_occ ? req_reg.time_ms - rec_rd.down_time : '0;
    assign spoil_up = spoiled_reg || (held > TIME_W'(cfg.hold_lim));
    assign count_up = slot_occ ? count_reg - 1'b1 : count_reg;

    assign mul_op = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign prod   = mul_op * mul_op;

    assign path_sum = {1'b0, rec_reg.path} + (PATH_W + 1)'(sqrt_root);
    assign path_new = path_sum[PATH_W] ? PATH_MAX : path_sum[PATH_W-1:0];

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        rec_next     = rec_reg;
        occ_next     = occ_reg;
        count_next   = count_reg;
        peak_next    = peak_reg;
        spoiled_next = spoiled_reg;
        start_next   = start_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sumsq_next   = sumsq_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        rec_wr       = rec_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                rec_next   = rec_rd;
                state_next = ST_IDLE;
                unique case (req_reg.mode)
                    MODE_DOWN: begin
                        if (slot_valid) begin
                            occ_next[slot_addr] = 1'b1;
                            count_next          = count_dn;
                            peak_next           = peak_dn;
                            spoiled_next        = spoil_dn;
                            start_next          = start_eff;
                            ram_we              = 1'b1;
                            rec_wr.last_x       = req_reg.pos_x;
                            rec_wr.last_y       = req_reg.pos_y;
                            rec_wr.path         = '0;
                            rec_wr.down_time    = req_reg.time_ms;
                        end
                    end
                    MODE_MOVE: begin
                        if (slot_occ) begin
                            dx_next = (req_reg.pos_x > rec_rd.last_x)
                                      ? req_reg.pos_x - rec_rd.last_x
                                      : rec_rd.last_x - req_reg.pos_x;
                            dy_next = (req_reg.pos_y > rec_rd.last_y)
                                      ? req_reg.pos_y - rec_rd.last_y
                                      : rec_rd.last_y - req_reg.pos_y;
                            state_next = ST_SQX;
                        end
                    end
                    MODE_UP: begin
                        if (slot_occ) begin
                            occ_next[slot_addr] = 1'b0;
                        end
                        count_next = count_up;
                        state_next = ST_OUT;
                        if (count_up != '0) begin
                            spoiled_next          = spoil_up;
                            res_next.decided      = 1'b0;
                            res_next.fired        = 1'b0;
                            res_next.fingers_left = count_up;
                            res_next.peak_fingers = '0;
                            res_next.was_spoiled  = 1'b0;
                        end else begin
                            res_next.decided      = 1'b1;
                            res_next.fired        = (peak_reg == TAP_COUNT) && !spoil_up;
                            res_next.fingers_left = '0;
                            res_next.peak_fingers = peak_reg;
                            res_next.was_spoiled  = spoil_up;
                            peak_next             = '0;
                            spoiled_next          = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SQX: begin
                sumsq_next = RAD_W'(prod);
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sumsq_next = sumsq_reg + RAD_W'(prod);
                state_next = ST_GO;
            end
            ST_GO: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                ram_we        = 1'b1;
                rec_wr.last_x = req_reg.pos_x;
                rec_wr.last_y = req_reg.pos_y;
                rec_wr.path   = path_new;
                if (path_new > PATH_W'(cfg.slop)) begin
                    spoiled_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            count_reg   <= '0;
            peak_reg    <= '0;
            spoiled_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            count_reg   <= count_next;
            peak_reg    <= peak_next;
            spoiled_reg <= spoiled_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        rec_reg    <= rec_next;
        start_reg  <= start_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sumsq_reg  <= sumsq_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
